@@ sv/spq_pkg.sv @@
// shared types and codes for the stable priority queue
// no dependencies; used by spq_cell and stable_priority_queue
`default_nettype none

package spq_pkg;

   // field widths fixed by the request and response formats
   localparam int ID_W    = 16;
   localparam int PAGES_W = 16;
   localparam int PRIO_W  = 8;
   localparam int STAT_W  = 2;
   localparam int OCC_W   = 5;

   // request opcodes
   localparam logic OP_ENQ = 1'b0;
   localparam logic OP_DEQ = 1'b1;

   // response status codes
   localparam logic [STAT_W-1:0] ST_ENQUEUED = 2'd0;
   localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
   localparam logic [STAT_W-1:0] ST_DEQUEUED = 2'd2;
   localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd3;

   // one stored job
   typedef struct packed {
      logic [PRIO_W-1:0]  prio;
      logic [PAGES_W-1:0] pages;
      logic [ID_W-1:0]    id;
   } job_type;

   // command broadcast to every cell of the chain
   typedef struct packed {
      logic    enq_en;
      logic    deq_en;
      job_type new_job;
   } cell_cmd_type;

   // what a cell hands on: stays flag and job to its right-hand neighbor, job to its left-hand one
   typedef struct packed {
      logic    stays;
      job_type job;
   } cell_link_type;

endpackage

`default_nettype wire

@@ sv/spq_cell.sv @@
// one slot of the sorted job chain: holds a job, compares and shifts
// depends on spq_pkg
`default_nettype none

module spq_cell #(
   parameter int INDEX = 0,
   parameter int CNT_W = 5
) (
   input  wire                      clock,
   input  wire spq_pkg::cell_cmd_type  cmd,
   input  wire [CNT_W-1:0]          count,
   input  wire spq_pkg::cell_link_type left_link,
   input  wire spq_pkg::job_type    right_job,
   output spq_pkg::cell_link_type   link
);

   spq_pkg::job_type job_ff;
   spq_pkg::job_type job_in;
   logic             occupied;
   logic             stays;

   // slot holds a job when its place is below the fill count
   assign occupied = (count > CNT_W'(INDEX));
   // job here is served no later than the new one, so it keeps its place
   assign stays    = occupied && (job_ff.prio <= cmd.new_job.prio);

   assign link.stays = stays;
   assign link.job   = job_ff;

   // next content: keep, take the new job, shift right on insert, shift left on removal
   always_comb begin
      job_in = job_ff;
      if (cmd.enq_en) begin
         if (!stays) begin
            job_in = left_link.stays ? cmd.new_job : left_link.job;
         end
      end else if (cmd.deq_en) begin
         job_in = right_job;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
   end

endmodule

`default_nettype wire

@@ sv/stable_priority_queue.sv @@
// stable priority queue: each request is answered from a registered response
// throughput one request per cycle while the response side does not stall; every cell compares and shifts in parallel
// request accepted while the response register is empty or being taken
// synchronous active-high reset empties the queue and the response register
// stored job contents are not cleared by reset
// depends on spq_pkg and spq_cell
`default_nettype none

module stable_priority_queue #(
   parameter int CAPACITY = 16
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   // job_id [15:0], page_count [31:16], priority_req [39:32]
   input  wire  [39:0] req_tdata,
   // opcode [0]
   input  wire  [0:0]  req_tuser,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   // out_job_id [15:0], out_page_count [31:16], out_priority [39:32],
   // occupancy [44:40], zero [47:45]
   output logic [47:0] rsp_tdata,
   // status [1:0]
   output logic [1:0]  rsp_tuser
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic                    req_fire;
   logic                    is_enq;
   logic                    is_deq;
   logic                    full;
   logic                    empty;
   spq_pkg::cell_cmd_type   cmd;
   spq_pkg::cell_link_type  cell_link [CAPACITY];

   logic [CNT_W-1:0]                count_ff;
   logic [CNT_W-1:0]                count_in;
   logic                            rsp_valid_ff;
   logic                            rsp_valid_in;
   logic [spq_pkg::STAT_W-1:0]      rsp_status_ff;
   logic [spq_pkg::STAT_W-1:0]      rsp_status_in;
   spq_pkg::job_type                rsp_job_ff;
   spq_pkg::job_type                rsp_job_in;
   logic [spq_pkg::OCC_W-1:0]       rsp_occ_ff;
   logic [spq_pkg::OCC_W-1:0]       rsp_occ_in;

   // request handshake
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;
   assign is_enq     = req_fire && (req_tuser[0] == spq_pkg::OP_ENQ);
   assign is_deq     = req_fire && (req_tuser[0] == spq_pkg::OP_DEQ);
   assign full       = (count_ff == CNT_W'(CAPACITY));
   assign empty      = (count_ff == '0);

   // command to the cell chain
   assign cmd.enq_en        = is_enq && !full;
   assign cmd.deq_en        = is_deq && !empty;
   assign cmd.new_job.id    = req_tdata[15:0];
   assign cmd.new_job.pages = req_tdata[31:16];
   assign cmd.new_job.prio  = req_tdata[39:32];

   // chain of cells, head at cell zero
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      spq_pkg::cell_link_type left_link;
      spq_pkg::job_type       right_job;

      if (i == 0) begin : g_head
         assign left_link.stays = 1'b1;
         assign left_link.job   = cmd.new_job;
      end else begin : g_mid
         assign left_link = cell_link[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign right_job = cell_link[i].job;
      end else begin : g_inner
         assign right_job = cell_link[i+1].job;
      end

      spq_cell #(
         .INDEX (i),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock     (clock),
         .cmd       (cmd),
         .count     (count_ff),
         .left_link (left_link),
         .right_job (right_job),
         .link      (cell_link[i])
      );
   end

   // fill count and response contents
   always_comb begin
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_job_in    = rsp_job_ff;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
         rsp_job_in   = '0;
         if (is_enq) begin
            if (full) begin
               rsp_status_in = spq_pkg::ST_FULL;
            end else begin
               rsp_status_in = spq_pkg::ST_ENQUEUED;
               count_in      = count_ff + CNT_W'(1);
            end
         end else begin
            if (empty) begin
               rsp_status_in = spq_pkg::ST_EMPTY;
            end else begin
               rsp_status_in = spq_pkg::ST_DEQUEUED;
               rsp_job_in    = cell_link[0].job;
               count_in      = count_ff - CNT_W'(1);
            end
         end
      end
   end

   assign rsp_occ_in = req_fire ? spq_pkg::OCC_W'(count_in) : rsp_occ_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload registers
   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_job_ff    <= rsp_job_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {3'b000, rsp_occ_ff, rsp_job_ff.prio, rsp_job_ff.pages, rsp_job_ff.id};

   // fill count never passes the capacity
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("job count above capacity");

   // an enqueue into a full queue is answered with the full status
   a_full_reject : assert property (@(posedge clock) disable iff (reset)
      (is_enq && full) |=> (rsp_tvalid && rsp_tuser == spq_pkg::ST_FULL))
      else $error("enqueue into full queue not rejected");

   // job fields are zero unless a job was dequeued
   a_zero_fields : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != spq_pkg::ST_DEQUEUED) |-> (rsp_tdata[39:0] == 40'd0))
      else $error("job fields not zero on non-dequeue response");

endmodule

`default_nettype wire
